[sv/outer_product_gradient_accumulator_macros.svh]
// Assertion macros shared by the gradient accumulator RTL.
// Depends on nothing; the including module must have clock and reset signals.
`ifndef OUTER_PRODUCT_GRADIENT_ACCUMULATOR_MACROS_SVH
`define OUTER_PRODUCT_GRADIENT_ACCUMULATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OPGA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OPGA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/opga_pkg.sv]
// Shared types and constants for the outer-product gradient accumulator.
// Depends on nothing; imported by opga_sat_add and the top-level accumulator.
`default_nettype none

package opga_pkg;

   // Default sizes, handed down as top-level parameter defaults.
   localparam int DEF_MAX_ROWS  = 64;
   localparam int DEF_MAX_COLS  = 64;
   localparam int DEF_ACC_WIDTH = 40;

   // Fixed field widths of the request and response beats.
   localparam int MODE_W  = 3;
   localparam int ROW_W   = 6;
   localparam int COL_W   = 6;
   localparam int VALUE_W = 16;
   localparam int RSP_W   = 40;
   localparam int BIAS_W  = 32;

   // Bias accumulator limits (Q17.15 in 32 bits).
   localparam logic signed [BIAS_W-1:0] BIAS_MAX = {1'b0, {(BIAS_W-1){1'b1}}};
   localparam logic signed [BIAS_W-1:0] BIAS_MIN = {1'b1, {(BIAS_W-1){1'b0}}};

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIAS_ENABLE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_IN_USE = 1'b1;
   localparam logic                   BIAS_ENABLE_RST = 1'b1;
   localparam logic [CSR_DATA_W-1:0]  COLS_IN_USE_RST = 7'd64;

   // Request operation codes.
   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD   = 3'd0,
      MODE_APPLY  = 3'd1,
      MODE_READ_W = 3'd2,
      MODE_READ_B = 3'd3,
      MODE_CLEAR  = 3'd4
   } mode_type;

   // Sequencer states, one-hot.
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_WALK  = 6'b000010,
      ST_BIAS  = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_READ  = 6'b010000,
      ST_SWEEP = 6'b100000
   } state_type;

endpackage

`default_nettype wire

[sv/opga_ram.sv]
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
`default_nettype none

module opga_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/opga_sat_add.sv]
// Shared saturating adder for weight and bias accumulators.
// Depends on opga_pkg for the bias accumulator limits.
`default_nettype none

module opga_sat_add #(
   parameter int ACC_WIDTH = opga_pkg::DEF_ACC_WIDTH
) (
   input  wire logic signed [ACC_WIDTH-1:0] acc,
   input  wire logic signed [ACC_WIDTH-1:0] addend,
   input  wire logic                        narrow,
   output logic      signed [ACC_WIDTH-1:0] sum,
   output logic                             sat
);

   import opga_pkg::*;

   localparam logic signed [ACC_WIDTH:0] WIDE_MAX   = {2'b00, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH:0] WIDE_MIN   = {2'b11, {(ACC_WIDTH-1){1'b0}}};
   localparam logic signed [ACC_WIDTH:0] NARROW_MAX = (ACC_WIDTH+1)'(BIAS_MAX);
   localparam logic signed [ACC_WIDTH:0] NARROW_MIN = (ACC_WIDTH+1)'(BIAS_MIN);

   logic signed [ACC_WIDTH:0] raw;
   logic signed [ACC_WIDTH:0] hi;
   logic signed [ACC_WIDTH:0] lo;

   // Full-precision sum, then clamp to the selected accumulator range.
   always_comb begin
      raw = (ACC_WIDTH+1)'(acc) + (ACC_WIDTH+1)'(addend);
      hi  = narrow ? NARROW_MAX : WIDE_MAX;
      lo  = narrow ? NARROW_MIN : WIDE_MIN;
      if (raw > hi) begin
         sum = hi[ACC_WIDTH-1:0];
         sat = 1'b1;
      end else if (raw < lo) begin
         sum = lo[ACC_WIDTH-1:0];
         sat = 1'b1;
      end else begin
         sum = raw[ACC_WIDTH-1:0];
         sat = 1'b0;
      end
   end

endmodule

`default_nettype wire

[sv/outer_product_gradient_accumulator.sv]
// Load: written at acceptance, block stays ready. Apply: walks n = min(cols_in_use, MAX_COLS)
// columns, then a bias step if bias is enabled, then drains; one column a cycle through the
// multiplier and shared adder. Weight read / bias read: the result beat comes from the
// registered memory read via the response register, held while an earlier response stalls.
// Clear and reset: a clearing pass over the weight and bias memories, no request accepted
// meanwhile. Reset is synchronous and active high; it also clears the column active mask.
`default_nettype none
`include "outer_product_gradient_accumulator_macros.svh"

module outer_product_gradient_accumulator #(
   parameter int MAX_ROWS  = opga_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS  = opga_pkg::DEF_MAX_COLS,
   parameter int ACC_WIDTH = opga_pkg::DEF_ACC_WIDTH
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [opga_pkg::MODE_W-1:0]          req_mode,
   input  wire logic [opga_pkg::ROW_W-1:0]           req_row,
   input  wire logic [opga_pkg::COL_W-1:0]           req_col,
   input  wire logic signed [opga_pkg::VALUE_W-1:0]  req_value,
   input  wire logic                                 req_active,
   // Response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [opga_pkg::RSP_W-1:0]         rsp_read_data,
   output logic                                      rsp_saturated,
   // Configuration port
   input  wire logic                                 csr_write_en,
   input  wire logic [opga_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [opga_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   import opga_pkg::*;

   localparam int RAW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CAW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int WAW    = RAW + CAW;
   localparam int NW     = $clog2(MAX_COLS + 1);
   localparam int WDEPTH = 2 ** WAW;
   localparam int BDEPTH = 2 ** RAW;
   localparam int ADEPTH = 2 ** CAW;

   // Control state
   state_type             state_ff, state_in;
   logic                  bias_en_ff, bias_en_in;
   logic [CSR_DATA_W-1:0] cols_ff, cols_in;
   logic [MAX_COLS-1:0]   mask_ff, mask_in;
   logic [NW-1:0]         cnt_ff, cnt_in;
   logic [WAW-1:0]        sweep_ff, sweep_in;
   logic                  s1_vld_ff, s1_vld_in;
   logic                  s2_vld_ff, s2_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Item and pipeline payload
   logic [RAW-1:0]               row_ff;
   logic signed [VALUE_W-1:0]    delta_ff;
   logic [NW-1:0]                n_ff;
   logic                         rd_bias_ff, rd_ok_ff;
   logic                         s1_bias_ff, s1_bias_in;
   logic                         s1_active_ff, s1_active_in;
   logic [WAW-1:0]               s1_addr_ff, s1_addr_in;
   logic                         s2_bias_ff, s2_active_ff, s2_mark_ff, s2_mark_in;
   logic [WAW-1:0]               s2_addr_ff;
   logic signed [ACC_WIDTH-1:0]  s2_acc_ff, s2_acc_in;
   logic signed [ACC_WIDTH-1:0]  s2_addend_ff, s2_addend_in;
   logic signed [RSP_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                         rsp_sat_ff, rsp_sat_in;

   // Decode and datapath nets
   logic                         accept;
   logic                         is_load, is_apply, is_read_w, is_read_b, is_clear;
   logic [RAW-1:0]               row_idx;
   logic [CAW-1:0]               col_idx;
   logic [CAW-1:0]               walk_col;
   logic                         row_ok, col_ok;
   logic [NW-1:0]                n_clamp;
   logic                         issue_w, issue_b, sweeping, rsp_load;
   logic                         in_apply, in_read;
   logic signed [2*VALUE_W-1:0]  product;
   logic signed [ACC_WIDTH-1:0]  sum;
   logic                         sat;

   // Memory ports
   logic                 w_wr_en, w_rd_en;
   logic [WAW-1:0]       w_wr_addr, w_rd_addr;
   logic [ACC_WIDTH:0]   w_wr_data, w_rd_data;
   logic                 b_wr_en, b_rd_en;
   logic [RAW-1:0]       b_wr_addr, b_rd_addr;
   logic [BIAS_W:0]      b_wr_data, b_rd_data;
   logic                 a_wr_en;
   logic [VALUE_W-1:0]   a_rd_data;

   // Request decode
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign row_idx   = RAW'(req_row);
   assign col_idx   = CAW'(req_col);
   assign row_ok    = int'(req_row) < MAX_ROWS;
   assign col_ok    = int'(req_col) < MAX_COLS;
   assign n_clamp   = (int'(cols_ff) > MAX_COLS) ? NW'(MAX_COLS) : NW'(cols_ff);
   assign walk_col  = cnt_ff[CAW-1:0];
   assign issue_w   = (state_ff == ST_WALK);
   assign issue_b   = (state_ff == ST_BIAS) && bias_en_ff;
   assign sweeping  = (state_ff == ST_SWEEP);
   assign in_read   = (state_ff == ST_READ);
   assign in_apply  = (state_ff == ST_WALK) || (state_ff == ST_BIAS) || (state_ff == ST_DRAIN);
   assign rsp_load  = in_read && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      is_load   = 1'b0;
      is_apply  = 1'b0;
      is_read_w = 1'b0;
      is_read_b = 1'b0;
      is_clear  = 1'b0;
      case (mode_type'(req_mode))
         MODE_LOAD:   is_load   = 1'b1;
         MODE_APPLY:  is_apply  = 1'b1;
         MODE_READ_W: is_read_w = 1'b1;
         MODE_READ_B: is_read_b = 1'b1;
         MODE_CLEAR:  is_clear  = 1'b1;
         default:     is_load   = 1'b0;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_apply && row_ok) begin
                  state_in = (n_clamp == '0) ? ST_BIAS : ST_WALK;
               end else if (is_read_w || is_read_b) begin
                  state_in = ST_READ;
               end else if (is_clear) begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_WALK: begin
            if (cnt_ff + NW'(1) == n_ff) begin
               state_in = ST_BIAS;
            end
         end
         ST_BIAS: state_in = ST_DRAIN;
         ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (&sweep_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign cnt_in   = issue_w ? cnt_ff + NW'(1) : '0;
   assign sweep_in = sweeping ? sweep_ff + WAW'(1) : '0;

   // Configuration registers
   always_comb begin
      bias_en_in = bias_en_ff;
      cols_in    = cols_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_BIAS_ENABLE: bias_en_in = csr_write_data[0];
            CSR_COLS_IN_USE: cols_in    = csr_write_data;
            default:         cols_in    = cols_ff;
         endcase
      end
   end

   // Column active mask, written by load beats
   always_comb begin
      mask_in = mask_ff;
      if (accept && is_load && col_ok) begin
         mask_in[col_idx] = req_active;
      end
   end

   // Stage one: column or bias step issued, memory reads in flight
   assign s1_vld_in    = issue_w || issue_b;
   assign s1_bias_in   = issue_b;
   assign s1_active_in = issue_w ? mask_ff[walk_col] : 1'b1;
   assign s1_addr_in   = issue_b ? {row_ff, CAW'(0)} : {row_ff, walk_col};

   // Stage two operands: the product for a weight step, the delta for the bias step
   assign product = delta_ff * signed'(a_rd_data);

   always_comb begin
      if (s1_bias_ff) begin
         s2_acc_in    = ACC_WIDTH'(signed'(b_rd_data[BIAS_W-1:0]));
         s2_addend_in = ACC_WIDTH'(delta_ff);
         s2_mark_in   = b_rd_data[BIAS_W];
      end else begin
         s2_acc_in    = signed'(w_rd_data[ACC_WIDTH-1:0]);
         s2_addend_in = ACC_WIDTH'(product);
         s2_mark_in   = w_rd_data[ACC_WIDTH];
      end
   end
   assign s2_vld_in = s1_vld_ff;

   opga_sat_add #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_sat_add (
      .acc    (s2_acc_ff),
      .addend (s2_addend_ff),
      .narrow (s2_bias_ff),
      .sum    (sum),
      .sat    (sat)
   );

   // Weight memory: clearing pass, stage-two write-back, walk and read-beat reads
   assign w_wr_en   = sweeping || (s2_vld_ff && !s2_bias_ff && s2_active_ff);
   assign w_wr_addr = sweeping ? sweep_ff : s2_addr_ff;
   assign w_wr_data = sweeping ? '0 : {s2_mark_ff | sat, sum};
   assign w_rd_en   = (accept && is_read_w) || issue_w;
   assign w_rd_addr = issue_w ? {row_ff, walk_col} : {row_idx, col_idx};

   opga_ram #(
      .WIDTH (ACC_WIDTH + 1),
      .DEPTH (WDEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (w_wr_addr),
      .wr_data (w_wr_data),
      .rd_en   (w_rd_en),
      .rd_addr (w_rd_addr),
      .rd_data (w_rd_data)
   );

   // Bias memory, mark bit on top
   assign b_wr_en   = sweeping || (s2_vld_ff && s2_bias_ff);
   assign b_wr_addr = sweeping ? sweep_ff[WAW-1:CAW] : s2_addr_ff[WAW-1:CAW];
   assign b_wr_data = sweeping ? '0 : {s2_mark_ff | sat, sum[BIAS_W-1:0]};
   assign b_rd_en   = (accept && is_read_b) || issue_b;
   assign b_rd_addr = issue_b ? row_ff : row_idx;

   opga_ram #(
      .WIDTH (BIAS_W + 1),
      .DEPTH (BDEPTH)
   ) u_bias_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (b_wr_data),
      .rd_en   (b_rd_en),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   // Activation memory; the user must read an entry only once its column is loaded (unchecked).
   assign a_wr_en = accept && is_load && col_ok;

   opga_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (ADEPTH)
   ) u_act_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (col_idx),
      .wr_data (req_value),
      .rd_en   (issue_w),
      .rd_addr (walk_col),
      .rd_data (a_rd_data)
   );

   // Response register
   always_comb begin
      rsp_data_in = '0;
      rsp_sat_in  = 1'b0;
      if (rd_ok_ff) begin
         if (rd_bias_ff) begin
            rsp_data_in = RSP_W'(signed'(b_rd_data[BIAS_W-1:0]));
            rsp_sat_in  = b_rd_data[BIAS_W];
         end else begin
            rsp_data_in = RSP_W'(signed'(w_rd_data[ACC_WIDTH-1:0]));
            rsp_sat_in  = w_rd_data[ACC_WIDTH];
         end
      end
   end
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_saturated = rsp_sat_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         bias_en_ff   <= BIAS_ENABLE_RST;
         cols_ff      <= COLS_IN_USE_RST;
         mask_ff      <= '0;
         cnt_ff       <= '0;
         sweep_ff     <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bias_en_ff   <= bias_en_in;
         cols_ff      <= cols_in;
         mask_ff      <= mask_in;
         cnt_ff       <= cnt_in;
         sweep_ff     <= sweep_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff     <= row_idx;
         delta_ff   <= req_value;
         n_ff       <= n_clamp;
         rd_bias_ff <= is_read_b;
         rd_ok_ff   <= is_read_b ? row_ok : (row_ok && col_ok);
      end
      s1_bias_ff   <= s1_bias_in;
      s1_active_ff <= s1_active_in;
      s1_addr_ff   <= s1_addr_in;
      s2_bias_ff   <= s1_bias_ff;
      s2_active_ff <= s1_active_ff;
      s2_addr_ff   <= s1_addr_ff;
      s2_acc_ff    <= s2_acc_in;
      s2_addend_ff <= s2_addend_in;
      s2_mark_ff   <= s2_mark_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_sat_ff  <= rsp_sat_in;
      end
   end

   // Checks
   `OPGA_ASSERT_SAME(a_ready_pipe_empty, !req_stall, !s1_vld_ff && !s2_vld_ff, "pipeline busy")
   `OPGA_ASSERT_SAME(a_wb_in_apply, s2_vld_ff, in_apply, "write-back outside an apply")
   `OPGA_ASSERT_NEXT(a_rsp_from_read, !rsp_valid_ff && !in_read, !rsp_valid_ff, "stray response")
   `OPGA_ASSERT_NEXT(a_sweep_ends_idle, sweeping && (&sweep_ff), !req_stall, "sweep overran")

endmodule

`default_nettype wire
